>>> hw/rtl/body_gravity_euler_step_assert.svh
// Assertion macros for the body gravity integrator RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef BODY_GRAVITY_EULER_STEP_ASSERT_SVH
`define BODY_GRAVITY_EULER_STEP_ASSERT_SVH

// The condition must never hold while out of reset.
`define BGES_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bges: forbidden condition seen");

// When the antecedent holds, the consequent must hold in the next cycle.
`define BGES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bges: expected follow-up did not occur");

`endif

>>> hw/rtl/bges_pkg.sv
// Shared types and constants for the body gravity integrator.
// No dependencies; used by body_gravity_euler_step, bges_cfg and the checker.
package bges_pkg;

    localparam logic [30:0] TIME_STEP_RESET = 31'd1092;

    typedef enum logic [2:0] {
        REG_UNI_X,
        REG_UNI_Y,
        REG_UNI_Z,
        REG_ATT_X,
        REG_ATT_Y,
        REG_ATT_Z,
        REG_STRENGTH,
        REG_TIME_STEP
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] body_mass;
        logic               is_static;
    } body_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } result_t;

    typedef struct packed {
        logic [2:0][31:0] uni;
        logic [2:0][31:0] att;
        logic [31:0]      strength;
        logic [30:0]      time_step;
    } cfg_t;

    // Kinematic state carried alongside the distance and division units.
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic             is_static;
    } kin_t;

    typedef struct packed {
        kin_t             kin;
        logic             accel_on;
        logic [2:0]       neg;
        logic [2:0][63:0] num;
    } sq_side_t;

    typedef struct packed {
        kin_t       kin;
        logic       accel_on;
        logic       near_ok;
        logic [2:0] neg;
    } div_side_t;

endpackage

>>> hw/rtl/body_gravity_euler_step.sv
// Semi-implicit Euler step of one body per beat under uniform plus radial gravity, Q-format
// fixed point with FRAC_BITS fraction bits. One body is accepted every clock while body_stall
// is low. The pipeline runs through three front stages, the 32-stage square-root unit for the
// distance to the attractor, the 32-stage divider for the radial direction, five stages of
// acceleration, velocity and position arithmetic, and the output register. A one-entry skid
// buffer sits behind the output register; the pipeline holds only while it is full. Depends on
// bges_pkg, bges_cfg, bges_isqrt, bges_div3 and the assertion macro header.
`include "body_gravity_euler_step_assert.svh"

module body_gravity_euler_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               body_valid,
    output logic               body_stall,
    input  bges_pkg::body_t    body,
    output logic               result_valid,
    input  logic               result_stall,
    output bges_pkg::result_t  result
);

    localparam logic [31:0] NEAR_LIMIT = 32'((64'd1 << FRAC_BITS) / 64'd1000);
    localparam int SQ_SW  = $bits(bges_pkg::sq_side_t);
    localparam int DIV_SW = $bits(bges_pkg::div_side_t);

    bges_pkg::cfg_t cfg;
    logic           en;
    logic           skid_valid_reg;

    bges_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en         = !skid_valid_reg;
    assign body_stall = skid_valid_reg;

    // ---------------- Stage 1: offset to the attractor ----------------
    logic             v1_reg;
    bges_pkg::kin_t   kin1_reg;
    logic             acc_on1_reg;
    logic [2:0][31:0] d1_reg;
    bges_pkg::kin_t   kin_in;
    logic [2:0][31:0] d_next;

    assign kin_in.pos       = {body.pos_z, body.pos_y, body.pos_x};
    assign kin_in.vel       = {body.vel_z, body.vel_y, body.vel_x};
    assign kin_in.is_static = body.is_static;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            d_next[j] = cfg.att[j] - kin_in.pos[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= body_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kin1_reg    <= kin_in;
            acc_on1_reg <= !body.is_static && (body.body_mass > 32'sd0);
            d1_reg      <= d_next;
        end
    end

    // ---------------- Stage 2: squares and numerators ----------------
    logic             v2_reg;
    bges_pkg::kin_t   kin2_reg;
    logic             acc_on2_reg;
    logic [2:0]       neg2_reg;
    logic [2:0][63:0] sq2_reg;
    logic [2:0][63:0] num2_reg;
    logic [31:0]      s_mag;
    logic [2:0][31:0] d_mag;
    logic [2:0][63:0] sq_next;
    logic [2:0][63:0] num_next;
    logic [2:0]       neg_next;

    assign s_mag = cfg.strength[31] ? 32'd0 - cfg.strength : cfg.strength;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            d_mag[j]    = d1_reg[j][31] ? 32'd0 - d1_reg[j] : d1_reg[j];
            sq_next[j]  = 64'(d_mag[j]) * 64'(d_mag[j]);
            num_next[j] = 64'(d_mag[j]) * 64'(s_mag);
            neg_next[j] = d1_reg[j][31] ^ cfg.strength[31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kin2_reg    <= kin1_reg;
            acc_on2_reg <= acc_on1_reg;
            neg2_reg    <= neg_next;
            sq2_reg     <= sq_next;
            num2_reg    <= num_next;
        end
    end

    // ---------------- Stage 3: sum of squares ----------------
    logic               v3_reg;
    logic [63:0]        sum3_reg;
    bges_pkg::sq_side_t side3_reg;
    bges_pkg::sq_side_t side3_next;

    assign side3_next.kin      = kin2_reg;
    assign side3_next.accel_on = acc_on2_reg;
    assign side3_next.neg      = neg2_reg;
    assign side3_next.num      = num2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            side3_reg <= side3_next;
        end
    end

    // ---------------- Distance ----------------
    logic               sq_valid;
    logic [31:0]        radius;
    logic [SQ_SW-1:0]   sq_side_bits;
    bges_pkg::sq_side_t sq_side;

    bges_isqrt #(
        .SW (SQ_SW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (sum3_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .out_root  (radius),
        .out_side  (sq_side_bits)
    );

    assign sq_side = bges_pkg::sq_side_t'(sq_side_bits);

    // ---------------- Radial direction ----------------
    bges_pkg::div_side_t div_in_side;
    bges_pkg::div_side_t div_side;
    logic [DIV_SW-1:0]   div_side_bits;
    logic                div_valid;
    logic [2:0][31:0]    quo;

    assign div_in_side.kin      = sq_side.kin;
    assign div_in_side.accel_on = sq_side.accel_on;
    assign div_in_side.near_ok  = radius > NEAR_LIMIT;
    assign div_in_side.neg      = sq_side.neg;

    bges_div3 #(
        .SW (DIV_SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_side.num),
        .in_den    (radius),
        .in_side   (div_in_side),
        .out_valid (div_valid),
        .out_quo   (quo),
        .out_side  (div_side_bits)
    );

    assign div_side = bges_pkg::div_side_t'(div_side_bits);

    // ---------------- A1: acceleration ----------------
    logic             va1_reg;
    bges_pkg::kin_t   kina1_reg;
    logic [2:0][31:0] acc_reg;
    logic [2:0][31:0] acc_next;
    logic [31:0]      rad_term;

    always_comb
    begin
        rad_term = '0;
        for (int j = 0; j < 3; j++)
        begin
            rad_term    = div_side.neg[j] ? 32'd0 - quo[j] : quo[j];
            acc_next[j] = '0;
            if (div_side.accel_on)
            begin
                acc_next[j] = cfg.uni[j] + (div_side.near_ok ? rad_term : 32'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va1_reg <= 1'b0;
        end
        else if (en)
        begin
            va1_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kina1_reg <= div_side.kin;
            acc_reg   <= acc_next;
        end
    end

    // ---------------- A2: acceleration times dt ----------------
    logic                    va2_reg;
    bges_pkg::kin_t          kina2_reg;
    logic signed [2:0][63:0] dv_reg;
    logic signed [2:0][63:0] dv_next;
    logic signed [31:0]      dt_s;

    assign dt_s = {1'b0, cfg.time_step};

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dv_next[j] = $signed(acc_reg[j]) * dt_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va2_reg <= 1'b0;
        end
        else if (en)
        begin
            va2_reg <= va1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kina2_reg <= kina1_reg;
            dv_reg    <= dv_next;
        end
    end

    // ---------------- A3: new velocity ----------------
    logic             va3_reg;
    bges_pkg::kin_t   kina3_reg;
    logic [2:0][31:0] nvel3_reg;
    logic [2:0][31:0] nvel_next;

    // The arithmetic shift of the product floors toward minus infinity.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            nvel_next[j] = kina2_reg.vel[j] + dv_reg[j][FRAC_BITS+31:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va3_reg <= 1'b0;
        end
        else if (en)
        begin
            va3_reg <= va2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kina3_reg <= kina2_reg;
            nvel3_reg <= nvel_next;
        end
    end

    // ---------------- A4: velocity times dt ----------------
    logic                    va4_reg;
    bges_pkg::kin_t          kina4_reg;
    logic [2:0][31:0]        nvel4_reg;
    logic signed [2:0][63:0] dp_reg;
    logic signed [2:0][63:0] dp_next;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dp_next[j] = $signed(nvel3_reg[j]) * dt_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va4_reg <= 1'b0;
        end
        else if (en)
        begin
            va4_reg <= va3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kina4_reg <= kina3_reg;
            nvel4_reg <= nvel3_reg;
            dp_reg    <= dp_next;
        end
    end

    // ---------------- A5: new position and static bypass ----------------
    logic              va5_reg;
    bges_pkg::result_t res5_reg;
    bges_pkg::result_t res_next;
    logic [2:0][31:0]  npos;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            npos[j] = kina4_reg.pos[j] + dp_reg[j][FRAC_BITS+31:FRAC_BITS];
        end
        if (kina4_reg.is_static)
        begin
            res_next = {kina4_reg.pos[0], kina4_reg.pos[1], kina4_reg.pos[2],
                        kina4_reg.vel[0], kina4_reg.vel[1], kina4_reg.vel[2]};
        end
        else
        begin
            res_next = {npos[0], npos[1], npos[2],
                        nvel4_reg[0], nvel4_reg[1], nvel4_reg[2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va5_reg <= 1'b0;
        end
        else if (en)
        begin
            va5_reg <= va4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res5_reg <= res_next;
        end
    end

    // ---------------- Output register and skid buffer ----------------
    logic              out_valid_reg;
    bges_pkg::result_t out_data_reg;
    bges_pkg::result_t skid_data_reg;
    logic              out_load;

    assign out_load = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= skid_valid_reg || va5_reg;
            end
            if (skid_valid_reg)
            begin
                if (!result_stall)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (va5_reg && out_valid_reg && result_stall)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res5_reg;
        end
        if (!skid_valid_reg && out_valid_reg && result_stall)
        begin
            skid_data_reg <= res5_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // A beat parked in the skid buffer always has one ahead of it in the output register.
    `BGES_ASSERT_NEVER(a_skid_behind_out, skid_valid_reg && !out_valid_reg)
    // Once the output drains, the skid buffer empties on the next cycle.
    `BGES_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !result_stall, !skid_valid_reg)
    // A held pipeline keeps its last stage occupied.
    `BGES_ASSERT_NEXT(a_hold_last, !en && va5_reg, va5_reg)

endmodule

>>> hw/rtl/bges_cfg.sv
// APB register file holding the gravity laws and the time step.
// Depends on bges_pkg for the register codes and the cfg_t bundle.
module bges_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bges_pkg::cfg_t    cfg
);

    bges_pkg::cfg_t   cfg_reg;
    bges_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = bges_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.uni       <= '0;
            cfg_reg.att       <= '0;
            cfg_reg.strength  <= '0;
            cfg_reg.time_step <= bges_pkg::TIME_STEP_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                bges_pkg::REG_UNI_X:     cfg_reg.uni[0]    <= pwdata;
                bges_pkg::REG_UNI_Y:     cfg_reg.uni[1]    <= pwdata;
                bges_pkg::REG_UNI_Z:     cfg_reg.uni[2]    <= pwdata;
                bges_pkg::REG_ATT_X:     cfg_reg.att[0]    <= pwdata;
                bges_pkg::REG_ATT_Y:     cfg_reg.att[1]    <= pwdata;
                bges_pkg::REG_ATT_Z:     cfg_reg.att[2]    <= pwdata;
                bges_pkg::REG_STRENGTH:  cfg_reg.strength  <= pwdata;
                bges_pkg::REG_TIME_STEP: cfg_reg.time_step <= pwdata[30:0];
                default:                 cfg_reg.strength  <= cfg_reg.strength;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bges_pkg::REG_UNI_X:     prdata = cfg_reg.uni[0];
            bges_pkg::REG_UNI_Y:     prdata = cfg_reg.uni[1];
            bges_pkg::REG_UNI_Z:     prdata = cfg_reg.uni[2];
            bges_pkg::REG_ATT_X:     prdata = cfg_reg.att[0];
            bges_pkg::REG_ATT_Y:     prdata = cfg_reg.att[1];
            bges_pkg::REG_ATT_Z:     prdata = cfg_reg.att[2];
            bges_pkg::REG_STRENGTH:  prdata = cfg_reg.strength;
            bges_pkg::REG_TIME_STEP: prdata = {1'b0, cfg_reg.time_step};
            default:                 prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/bges_isqrt.sv
// Pipelined integer square root: floor(sqrt) of a 64-bit value, one root bit per stage.
// Standalone; carries an opaque sideband of SW bits along with each beat.
module bges_isqrt #(
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   in_rad,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [31:0]   out_root,
    output logic [SW-1:0] out_side
);

    logic [31:0]   rem_reg  [0:31];
    logic [31:0]   root_reg [0:31];
    logic [63:0]   rad_reg  [0:31];
    logic [SW-1:0] side_reg [0:31];
    logic          v_reg    [0:31];

    for (genvar k = 0; k < 32; k++)
    begin : g_stage
        logic [31:0]   r_in;
        logic [31:0]   q_in;
        logic [63:0]   n_in;
        logic [SW-1:0] s_in;
        logic          v_in;
        logic [33:0]   rem_sh;
        logic [33:0]   trial;
        logic [33:0]   rem_next;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_in = '0;
            assign q_in = '0;
            assign n_in = in_rad;
            assign s_in = in_side;
            assign v_in = in_valid;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[k-1];
            assign q_in = root_reg[k-1];
            assign n_in = rad_reg[k-1];
            assign s_in = side_reg[k-1];
            assign v_in = v_reg[k-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign rem_sh   = {r_in, n_in[63:62]};
        assign trial    = {q_in, 2'b01};
        assign ge       = rem_sh >= trial;
        assign rem_next = ge ? rem_sh - trial : rem_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next[31:0];
                root_reg[k] <= {q_in[30:0], ge};
                rad_reg[k]  <= {n_in[61:0], 2'b00};
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[31];
    assign out_root  = root_reg[31];
    assign out_side  = side_reg[31];

endmodule

>>> hw/rtl/bges_div3.sv
// Pipelined restoring divider: three 64-bit numerators over one 32-bit divisor.
// Quotients must fit 32 bits; one quotient bit per stage. Standalone module.
module bges_div3 #(
    parameter int SW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2:0][63:0] in_num,
    input  logic [31:0]      in_den,
    input  logic [SW-1:0]    in_side,
    output logic             out_valid,
    output logic [2:0][31:0] out_quo,
    output logic [SW-1:0]    out_side
);

    logic [2:0][31:0] rem_reg  [0:31];
    logic [2:0][31:0] low_reg  [0:31];
    logic [31:0]      den_reg  [0:31];
    logic [SW-1:0]    side_reg [0:31];
    logic             v_reg    [0:31];

    for (genvar k = 0; k < 32; k++)
    begin : g_stage
        logic [2:0][31:0] r_in;
        logic [2:0][31:0] l_in;
        logic [2:0][31:0] rem_next;
        logic [2:0][31:0] low_next;
        logic [31:0]      d_in;
        logic [SW-1:0]    s_in;
        logic             v_in;

        if (k == 0)
        begin : g_first
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign r_in[j] = in_num[j][63:32];
                assign l_in[j] = in_num[j][31:0];
            end
            assign d_in = in_den;
            assign s_in = in_side;
            assign v_in = in_valid;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[k-1];
            assign l_in = low_reg[k-1];
            assign d_in = den_reg[k-1];
            assign s_in = side_reg[k-1];
            assign v_in = v_reg[k-1];
        end

        // The low word shifts dividend bits out at the top and quotient bits in.
        for (genvar j = 0; j < 3; j++)
        begin : g_calc
            logic [32:0] rem_sh;
            logic [32:0] diff;
            logic        ge;

            assign rem_sh      = {r_in[j], l_in[j][31]};
            assign diff        = rem_sh - {1'b0, d_in};
            assign ge          = rem_sh >= {1'b0, d_in};
            assign rem_next[j] = ge ? diff[31:0] : rem_sh[31:0];
            assign low_next[j] = {l_in[j][30:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                den_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[31];
    assign out_quo   = low_reg[31];
    assign out_side  = side_reg[31];

endmodule

>>> dv/body_gravity_euler_step_checker.sv
// Checker for body_gravity_euler_step: tracks register writes on the APB port, predicts
// each body's stepped state and compares it with every result beat.
// Depends on bges_pkg for the payload types and register indexes.
module body_gravity_euler_step_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              body_valid,
    input  logic              body_stall,
    input  bges_pkg::body_t   body,
    input  logic              result_valid,
    input  logic              result_stall,
    input  bges_pkg::result_t result,
    output int                fails,
    output int                pending
);

    localparam longint unsigned NEAR_LIMIT = (64'd1 << FRAC_BITS) / 64'd1000;

    logic [31:0]       uni_acc [3];
    logic [31:0]       centre [3];
    logic [31:0]       pull;
    logic [30:0]       dt;
    bges_pkg::result_t stepped_q[$];

    assign pending = stepped_q.size();

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Product with dt, floored by the arithmetic shift, then wrapped.
    function automatic logic [31:0] scale_dt(logic [31:0] a);
        longint p;
        p = longint'(signed'(a)) * longint'({1'b0, dt});
        p = p >>> FRAC_BITS;
        return p[31:0];
    endfunction

    function automatic bges_pkg::result_t step_body(bges_pkg::body_t b);
        logic [31:0]       pos [3];
        logic [31:0]       vel [3];
        logic [31:0]       acc [3];
        logic [31:0]       dd;
        longint            d [3];
        longint            s;
        longint unsigned   mag [3];
        longint unsigned   smag;
        longint unsigned   sumsq;
        longint unsigned   radius;
        longint unsigned   q;
        bges_pkg::result_t r;
        pos[0] = b.pos_x; pos[1] = b.pos_y; pos[2] = b.pos_z;
        vel[0] = b.vel_x; vel[1] = b.vel_y; vel[2] = b.vel_z;
        sumsq = 0;
        if (!b.is_static)
        begin
            for (int i = 0; i < 3; i++)
                acc[i] = '0;
            if (b.body_mass > 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dd = centre[i] - pos[i];
                    d[i] = longint'(signed'(dd));
                    mag[i] = (d[i] < 0) ? -d[i] : d[i];
                    sumsq += mag[i] * mag[i];
                    acc[i] = uni_acc[i];
                end
                radius = root_floor(sumsq);
                if (radius > NEAR_LIMIT)
                begin
                    s = longint'(signed'(pull));
                    smag = (s < 0) ? -s : s;
                    for (int i = 0; i < 3; i++)
                    begin
                        q = (mag[i] * smag) / radius;
                        if ((d[i] < 0) != (s < 0))
                            q = -q;
                        acc[i] += q[31:0];
                    end
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                vel[i] += scale_dt(acc[i]);
                pos[i] += scale_dt(vel[i]);
            end
        end
        r.new_pos_x = pos[0]; r.new_pos_y = pos[1]; r.new_pos_z = pos[2];
        r.new_vel_x = vel[0]; r.new_vel_y = vel[1]; r.new_vel_z = vel[2];
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                uni_acc[i] <= '0;
                centre[i]  <= '0;
            end
            pull <= '0;
            dt   <= bges_pkg::TIME_STEP_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (bges_pkg::reg_idx_t'(paddr[4:2]))
                bges_pkg::REG_UNI_X:     uni_acc[0] <= pwdata;
                bges_pkg::REG_UNI_Y:     uni_acc[1] <= pwdata;
                bges_pkg::REG_UNI_Z:     uni_acc[2] <= pwdata;
                bges_pkg::REG_ATT_X:     centre[0]  <= pwdata;
                bges_pkg::REG_ATT_Y:     centre[1]  <= pwdata;
                bges_pkg::REG_ATT_Z:     centre[2]  <= pwdata;
                bges_pkg::REG_STRENGTH:  pull       <= pwdata;
                bges_pkg::REG_TIME_STEP: dt         <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        bges_pkg::result_t want;
        if (rst_n && body_valid && !body_stall)
            stepped_q = {stepped_q, step_body(body)};
        if (rst_n && result_valid && !result_stall)
        begin
            if (stepped_q.size() == 0)
                report("result with nothing outstanding", result[31:0], '0);
            else
            begin
                want = stepped_q.pop_front();
                if (result.new_pos_x !== want.new_pos_x)
                    report("new_pos_x", result.new_pos_x, want.new_pos_x);
                if (result.new_pos_y !== want.new_pos_y)
                    report("new_pos_y", result.new_pos_y, want.new_pos_y);
                if (result.new_pos_z !== want.new_pos_z)
                    report("new_pos_z", result.new_pos_z, want.new_pos_z);
                if (result.new_vel_x !== want.new_vel_x)
                    report("new_vel_x", result.new_vel_x, want.new_vel_x);
                if (result.new_vel_y !== want.new_vel_y)
                    report("new_vel_y", result.new_vel_y, want.new_vel_y);
                if (result.new_vel_z !== want.new_vel_z)
                    report("new_vel_z", result.new_vel_z, want.new_vel_z);
            end
        end
    end

endmodule

>>> dv/tb_body_gravity_euler_step.sv
// Testbench top for body_gravity_euler_step: drives register writes and body beats with
// random gaps and output stalls, and gives the verdict. Depends on bges_pkg, DUT, checker.
module tb_body_gravity_euler_step;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              body_valid = 1'b0;
    logic              body_stall;
    bges_pkg::body_t   body = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    bges_pkg::result_t result;
    int                fails;
    int                pending;
    int                cycles = 0;
    int                in_quiet = 0;
    int                out_quiet = 0;
    logic [31:0]       att_copy [3];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    body_gravity_euler_step dut (.*);

    body_gravity_euler_step_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_body_gravity_euler_step: errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Output stall pattern; quiet stretches give back-to-back results.
    always @(posedge clk)
    begin
        if (out_quiet > 0)
        begin
            out_quiet <= out_quiet - 1;
            result_stall <= 1'b0;
        end
        else if ($urandom_range(199) == 0)
            out_quiet <= $urandom_range(300, 50);
        else if ($urandom_range(99) < 8)
            result_stall <= ($urandom_range(4) != 0) ? 1'b1 : 1'b0;
        else if ($urandom_range(99) < 30)
            result_stall <= ~result_stall;
    end

    task automatic reg_write(bges_pkg::reg_idx_t idx, logic [31:0] val);
        logic ready;
        if (idx == bges_pkg::REG_ATT_X) att_copy[0] = val;
        if (idx == bges_pkg::REG_ATT_Y) att_copy[1] = val;
        if (idx == bges_pkg::REG_ATT_Z) att_copy[2] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ready = pready;
            @(posedge clk);
        end
        while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                             logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] st, logic [31:0] dt);
        reg_write(bges_pkg::REG_UNI_X, ux);
        reg_write(bges_pkg::REG_UNI_Y, uy);
        reg_write(bges_pkg::REG_UNI_Z, uz);
        reg_write(bges_pkg::REG_ATT_X, ax);
        reg_write(bges_pkg::REG_ATT_Y, ay);
        reg_write(bges_pkg::REG_ATT_Z, az);
        reg_write(bges_pkg::REG_STRENGTH, st);
        reg_write(bges_pkg::REG_TIME_STEP, dt);
    endtask

    task automatic send_body(bges_pkg::body_t b);
        int   gap;
        logic stalled;
        gap = (in_quiet > 0) ? 0 : gap_len();
        if (in_quiet > 0)
            in_quiet--;
        else if ($urandom_range(149) == 0)
            in_quiet = $urandom_range(120, 30);
        if (gap > 0)
        begin
            body_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        body_valid <= 1'b1;
        body <= b;
        do
        begin
            @(negedge clk);
            stalled = body_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    // The first wait lets the checker record the last accepted beat.
    task automatic drain();
        body_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h000f_ffff);
            3: return -$urandom_range(32'h000f_ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic bges_pkg::body_t rand_body();
        bges_pkg::body_t b;
        int              r;
        b.pos_x = pick32(); b.pos_y = pick32(); b.pos_z = pick32();
        b.vel_x = pick32(); b.vel_y = pick32(); b.vel_z = pick32();
        r = $urandom_range(99);
        // Bodies right on or near the attractor exercise the near-centre cutoff.
        if (r < 12)
        begin
            b.pos_x = att_copy[0] + $urandom_range(80) - 40;
            b.pos_y = att_copy[1] + $urandom_range(80) - 40;
            b.pos_z = att_copy[2] + $urandom_range(80) - 40;
        end
        r = $urandom_range(99);
        if (r < 70)
            b.body_mass = $urandom_range(32'h7fff_ffff, 1);
        else if (r < 80)
            b.body_mass = '0;
        else
            b.body_mass = $urandom | 32'h8000_0000;
        b.is_static = ($urandom_range(9) == 0);
        return b;
    endfunction

    function automatic bges_pkg::body_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                           logic [31:0] vx, logic [31:0] m, logic st);
        bges_pkg::body_t b;
        b.pos_x = px; b.pos_y = py; b.pos_z = pz;
        b.vel_x = vx; b.vel_y = -vx; b.vel_z = vx ^ 32'h5555_5555;
        b.body_mass = m;
        b.is_static = st;
        return b;
    endfunction

    initial
    begin
        att_copy[0] = '0; att_copy[1] = '0; att_copy[2] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first: only the default time step applies.
        send_body(mk(32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0003_0000,
                     32'h0001_0000, 1'b0));
        drain();

        write_all(32'hfff6_0000, 32'h0000_8000, 32'h0001_0000, '0, '0, '0,
                  32'h0005_0000, 32'h0000_1000);
        send_body(mk('0, '0, '0, 32'h0001_0000, 32'h0001_0000, 1'b0));
        send_body(mk(-32'd65, '0, '0, '0, 32'h0001_0000, 1'b0));
        send_body(mk(-32'd66, '0, '0, '0, 32'h0001_0000, 1'b0));
        send_body(mk(32'd40, 32'd40, 32'd40, '0, 32'h0000_0001, 1'b0));
        send_body(mk(32'd38, 32'd38, 32'd38, '0, 32'h0000_0001, 1'b0));
        send_body(mk(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32'h0001_0000,
                     32'h0001_0000, 1'b1));
        send_body(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 1'b1));
        send_body(mk(32'h0010_0000, 32'hfff0_0000, 32'h0000_1234, 32'h0002_0000,
                     '0, 1'b0));
        send_body(mk(32'h0010_0000, 32'hfff0_0000, 32'h0000_1234, 32'h0002_0000,
                     32'h8000_0000, 1'b0));
        send_body(mk(32'h0010_0000, 32'hfff0_0000, 32'h0000_1234, 32'hfffe_0000,
                     32'hffff_ffff, 1'b0));
        send_body(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 1'b0));
        send_body(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 1'b0));
        send_body(mk(32'h8000_0000, 32'h7fff_ffff, '0, 32'h8000_0000, 32'h0000_0001, 1'b0));
        drain();

        // Register extremes, then the opposite extremes with a zero step.
        write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_body(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'h7fff_ffff, 1'b0));
        send_body(mk('0, '0, '0, 32'h8000_0000, 32'h0001_0000, 1'b0));
        send_body(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h0001_0000, 1'b0));
        send_body(mk(32'h7fff_ff00, 32'h8000_0000, '0, 32'hffff_ffff, 32'h0000_0001, 1'b0));
        drain();
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, '0);
        send_body(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 1'b0));
        send_body(mk('0, '0, '0, 32'h0001_0000, 32'h0001_0000, 1'b0));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: write_all(pick32(), pick32(), pick32(), pick32(), pick32(), pick32(),
                             pick32(), $urandom);
                1: write_all($urandom_range(32'h000a_0000) - 32'h0005_0000,
                             $urandom_range(32'h000a_0000) - 32'h0005_0000,
                             $urandom_range(32'h000a_0000) - 32'h0005_0000,
                             $urandom, $urandom, $urandom,
                             $urandom_range(32'h0100_0000) - 32'h0080_0000,
                             $urandom_range(32'h0000_4000));
                2: write_all($urandom, $urandom, $urandom, pick32(), pick32(), pick32(),
                             '0, $urandom_range(32'h0001_0000));
                default: write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
            endcase
            repeat (230) send_body(rand_body());
            drain();
        end

        if (fails == 0)
            $display("tb_body_gravity_euler_step: clean");
        else
            $display("tb_body_gravity_euler_step: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bges_pkg.sv
hw/rtl/bges_cfg.sv
hw/rtl/bges_isqrt.sv
hw/rtl/bges_div3.sv
hw/rtl/body_gravity_euler_step.sv
dv/body_gravity_euler_step_checker.sv
dv/tb_body_gravity_euler_step.sv
